>>> design/spf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_pkg
// shared constants and state encodings for the smallest-prime-factor block
// ----------------------------------------------------------------------------
package spf_pkg;
  localparam int unsigned VALUE_BITS_DEF = 16;
  localparam int unsigned PRIME_CAP_DEF  = 8192;
  localparam int unsigned FIELD_W        = 16;
  localparam int unsigned RESULT_CAP     = 6;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_SV_RD,
    ST_SV_CHK,
    ST_SV_PRD,
    ST_SV_PL,
    ST_SV_WR,
    ST_IDLE,
    ST_LOOK,
    ST_START,
    ST_DIV,
    ST_EMIT,
    ST_ZERO
  } spf_state_t;
endpackage

>>> design/spf_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_divider
// restoring divider, one quotient bit per cycle, quotient and remainder out
// ----------------------------------------------------------------------------
module spf_divider #(
  parameter int unsigned W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;
endmodule

>>> design/spf_sieve_factorizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_sieve_factorizer
// linear-sieve smallest-prime-factor table and distinct prime factorizer
// ----------------------------------------------------------------------------
// After reset the block clears its factor table, then runs a linear sieve
// over 2..2^VALUE_BITS-1. in_stall stays high until the sieve is done,
// then the block takes one in_value item at a time. Each item gives its
// distinct prime factors in ascending order on out_factor, one per out
// item, with out_last on the final one; a value of 0 or 1 gives a single
// item with factor 0.
// Per factor the block does one table read and repeated divisions by that
// factor through a shared bit-serial divider.
// in_stall is high from acceptance until the last factor item is loaded into
// the out register, so the next item can start while that one waits.
// While out_stall is high the out item holds and the loop waits before
// loading its next out item.
// ----------------------------------------------------------------------------
module spf_sieve_factorizer #(
  parameter int unsigned VALUE_BITS = spf_pkg::VALUE_BITS_DEF,
  parameter int unsigned PRIME_CAP  = spf_pkg::PRIME_CAP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [spf_pkg::FIELD_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [spf_pkg::FIELD_W-1:0] out_factor,
  output logic                        out_last
);
  import spf_pkg::*;

  localparam int unsigned DEPTH = 1 << VALUE_BITS;
  localparam int unsigned PW    = $clog2(PRIME_CAP);
  localparam int unsigned CW    = PW + 1;
  localparam int unsigned VB    = VALUE_BITS;
  localparam int unsigned NW    = $clog2(RESULT_CAP + 1);

  logic [VB-1:0] spf_mem [DEPTH];
  logic [VB-1:0] prime_mem [PRIME_CAP];

  spf_state_t    st_r, st_nxt;
  logic [VB:0]   i_r, i_nxt;       // sieve index, also clear address
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] pcnt_r, pcnt_nxt;
  logic [VB-1:0] spfi_r, spfi_nxt;
  logic [VB-1:0] p_r, p_nxt;
  logic [2*VB-1:0] prod_r, prod_nxt;
  logic [VB-1:0] x_r, x_nxt;
  logic [VB-1:0] y_r, y_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          ov_r, ov_nxt;
  logic [FIELD_W-1:0] of_r, of_nxt;
  logic          ol_r, ol_nxt;

  logic          we;
  logic [VB-1:0] waddr, wdata;
  logic [VB-1:0] raddr;
  logic [VB-1:0] rdata_r;
  logic          pwe;
  logic [PW-1:0] praddr;
  logic [VB-1:0] prdata_r;

  logic          dv_start, dv_done;
  logic [VB-1:0] dv_q, dv_rem;
  logic [VB-1:0] y_eff;
  logic          out_take;
  logic          more;

  spf_divider #(.W(VB)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(x_r),
    .divisor(y_r), .done(dv_done), .quotient(dv_q), .remainder(dv_rem)
  );

  always_ff @(posedge clk) begin
    if (we) spf_mem[waddr] <= wdata;
    rdata_r <= spf_mem[raddr];
    if (pwe) prime_mem[pcnt_r[PW-1:0]] <= i_r[VB-1:0];
    prdata_r <= prime_mem[praddr];
  end

  assign out_take = ov_r && !out_stall;
  assign y_eff    = (rdata_r < VB'(2)) ? x_r : rdata_r;
  assign more     = (x_r > VB'(1)) && (n_r < NW'(RESULT_CAP));

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR:  if (i_r == (VB+1)'(DEPTH - 1)) st_nxt = ST_SV_RD;
      ST_SV_RD:  st_nxt = (i_r == (VB+1)'(DEPTH)) ? ST_IDLE : ST_SV_CHK;
      ST_SV_CHK: st_nxt = ST_SV_PRD;
      ST_SV_PRD: st_nxt = ST_SV_PL;
      ST_SV_PL:  st_nxt = (prdata_r > spfi_r) ? ST_SV_RD : ST_SV_WR;
      ST_SV_WR:  st_nxt = ((prod_r < (2*VB)'(DEPTH)) && (j_r + 1'b1 < pcnt_r)) ?
                          ST_SV_PL : ST_SV_RD;
      ST_IDLE:   if (in_valid) st_nxt = (VB'(in_value) < VB'(2)) ? ST_ZERO : ST_LOOK;
      ST_LOOK:   st_nxt = ST_START;
      ST_START:  st_nxt = ST_DIV;
      ST_DIV:    if (dv_done) st_nxt = (dv_rem == '0) ? ST_START : ST_EMIT;
      ST_EMIT:   if (!ov_r || out_take) st_nxt = more ? ST_LOOK : ST_IDLE;
      ST_ZERO:   if (!ov_r || out_take) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    i_nxt = i_r; j_nxt = j_r; pcnt_nxt = pcnt_r; spfi_nxt = spfi_r;
    p_nxt = p_r; prod_nxt = prod_r; x_nxt = x_r; y_nxt = y_r; n_nxt = n_r;
    ov_nxt = ov_r && !out_take; of_nxt = of_r; ol_nxt = ol_r;
    we = 1'b0; waddr = i_r[VB-1:0]; wdata = '0;
    raddr = i_r[VB-1:0]; pwe = 1'b0; praddr = j_r[PW-1:0];
    dv_start = 1'b0;
    in_stall = (st_r != ST_IDLE);
    case (st_r)
      ST_CLEAR: begin
        we = 1'b1;
        i_nxt = (i_r == (VB+1)'(DEPTH - 1)) ? (VB+1)'(2) : i_r + 1'b1;
      end
      ST_SV_RD: j_nxt = '0;
      ST_SV_CHK: begin
        spfi_nxt = rdata_r;
        if (rdata_r == '0) begin
          spfi_nxt = i_r[VB-1:0];
          we = 1'b1; wdata = i_r[VB-1:0];
          if (pcnt_r < CW'(PRIME_CAP)) begin
            pwe = 1'b1;
            pcnt_nxt = pcnt_r + 1'b1;
          end
        end
      end
      ST_SV_PRD: ;
      ST_SV_PL: begin
        if (prdata_r > spfi_r) begin
          i_nxt = i_r + 1'b1;
        end else begin
          p_nxt = prdata_r;
          prod_nxt = {{VB{1'b0}}, prdata_r} * {{VB{1'b0}}, i_r[VB-1:0]};
        end
      end
      ST_SV_WR: begin
        if (prod_r < (2*VB)'(DEPTH)) begin
          we = 1'b1; waddr = prod_r[VB-1:0]; wdata = p_r;
          // fetch the next prime while this write goes in
          if (j_r + 1'b1 < pcnt_r) begin
            j_nxt = j_r + 1'b1;
            praddr = PW'(j_r + 1'b1);
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_IDLE: begin
        x_nxt = VB'(in_value);
        n_nxt = '0;
        raddr = VB'(in_value);
      end
      ST_LOOK: begin
        y_nxt = y_eff;
        n_nxt = n_r + 1'b1;
      end
      ST_START: dv_start = 1'b1;
      ST_DIV: if (dv_done && dv_rem == '0) x_nxt = dv_q;
      ST_EMIT: begin
        raddr = x_r;
        if (!ov_r || out_take) begin
          ov_nxt = 1'b1;
          of_nxt = FIELD_W'(y_r);
          ol_nxt = !more;
        end
      end
      ST_ZERO: if (!ov_r || out_take) begin
        ov_nxt = 1'b1; of_nxt = '0; ol_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLEAR;
      i_r    <= '0;
      j_r    <= '0;
      pcnt_r <= '0;
      ov_r   <= 1'b0;
      n_r    <= '0;
    end else begin
      st_r   <= st_nxt;
      i_r    <= i_nxt;
      j_r    <= j_nxt;
      pcnt_r <= pcnt_nxt;
      ov_r   <= ov_nxt;
      n_r    <= n_nxt;
    end
    spfi_r <= spfi_nxt;
    p_r    <= p_nxt;
    prod_r <= prod_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    of_r   <= of_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_valid  = ov_r;
  assign out_factor = of_r;
  assign out_last   = ol_r;
endmodule
